// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the potentiometer percent block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("assertion failed");

// Same-cycle implication
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/ppma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppma_pkg
// Constants and types shared by the potentiometer percent moving average.
// ----------------------------------------------------------------------------
package ppma_pkg;

  // Default geometry
  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int SAMPLE_BITS_DEF  = 12;

  // Percent format: unsigned, 8 fraction bits, 100.0 percent = 25600
  localparam int PCT_BITS  = 15;
  localparam int PCT_FULL  = 25600;
  localparam int QUOT_BITS = 15;

  // Configuration register reset values
  localparam int RANGE_LOW_RESET  = 0;
  localparam int RANGE_HIGH_RESET = 4095;

  // Configuration register index
  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_RANGE_LOW  = 2'd0,
    REG_RANGE_HIGH = 2'd1
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RAW,
    ST_WINDOW,
    ST_DIV_AVG,
    ST_DONE
  } ppma_state_t;

endpackage

// ===== rtl/core/ppma_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppma_ifs
// Valid/ready channels: sample input, result output, register writes.
// ----------------------------------------------------------------------------

// Raw converter sample channel
interface ppma_sample_if #(
  parameter int SAMPLE_BITS = ppma_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

// Percent result channel
interface ppma_result_if;
  logic                          valid;
  logic                          ready;
  logic [ppma_pkg::PCT_BITS-1:0] raw_percent;
  logic [ppma_pkg::PCT_BITS-1:0] average_percent;

  modport source (output valid, output raw_percent, output average_percent, input ready);
  modport sink   (input valid, input raw_percent, input average_percent, output ready);
endinterface

// Register write channel
interface ppma_cfg_if #(
  parameter int DATA_BITS = ppma_pkg::SAMPLE_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic [ppma_pkg::CFG_INDEX_BITS-1:0] index;
  logic [DATA_BITS-1:0]                data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/pot_percent_moving_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pot_percent_moving_average
// Maps a potentiometer count onto 0..100 percent and averages over a window.
// ----------------------------------------------------------------------------
// One item at a time: a sample is taken in IDLE, its percent is found by a
// restoring divider that produces one quotient bit per cycle, the window and
// running sum are updated in WINDOW, and the same divider then forms the
// average. No new sample is taken until the last one has left DONE, and the
// raw division is skipped when the percent is settled without division
// (equal range ends, or a sample at or beyond either end of the range). The
// result sits in an output register, so a sample can be taken while the
// previous result still waits; configuration writes are always ready and
// take effect on the next sample.
`include "assert_macros.svh"

module pot_percent_moving_average #(
  parameter int WINDOW_DEPTH = ppma_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_BITS  = ppma_pkg::SAMPLE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  ppma_cfg_if.sink       cfg,
  ppma_sample_if.sink    sample,
  ppma_result_if.source  result
);
  import ppma_pkg::*;

  localparam int CNT_BITS = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_BITS = PCT_BITS + CNT_BITS;
  localparam int DEN_BITS = (SAMPLE_BITS > CNT_BITS) ? SAMPLE_BITS : CNT_BITS;
  localparam int DVD_BITS = SAMPLE_BITS + QUOT_BITS;
  localparam int BIT_BITS = $clog2(QUOT_BITS);

  // 100.0 percent in the result format
  localparam logic [PCT_BITS-1:0] PCT_TOP = PCT_BITS'(PCT_FULL);

  // Configuration registers
  logic [SAMPLE_BITS-1:0] range_low;
  logic [SAMPLE_BITS-1:0] range_high;

  // Window state
  logic [PCT_BITS-1:0]    history [WINDOW_DEPTH];
  logic [SUM_BITS-1:0]    win_sum;
  logic [CNT_BITS-1:0]    samples_seen;

  // Sequencer
  ppma_state_t            state;
  ppma_state_t            state_next;

  // Serial divider
  logic [DEN_BITS-1:0]    rem;
  logic [DEN_BITS-1:0]    den;
  logic [QUOT_BITS-1:0]   quo;
  logic [BIT_BITS-1:0]    bit_cnt;

  logic [PCT_BITS-1:0]    raw_pct;

  // Output register
  logic                   out_valid;
  logic [PCT_BITS-1:0]    out_raw;
  logic [PCT_BITS-1:0]    out_avg;

  // Control decodes
  logic                   in_ready;
  logic                   div_run;
  logic                   div_last;
  logic                   out_free;

  // Front-end mapping terms
  logic                   num_neg;
  logic                   den_neg;
  logic [SAMPLE_BITS-1:0] num_mag;
  logic [SAMPLE_BITS-1:0] den_mag;
  logic                   raw_zero;
  logic                   raw_full;
  logic [SAMPLE_BITS+6:0] num_x100;
  logic [DVD_BITS-1:0]    raw_dvd;

  // Divider step terms
  logic [DEN_BITS:0]      trial;
  logic                   q_bit;
  logic [DEN_BITS-1:0]    rem_step;
  logic [QUOT_BITS-1:0]   quo_step;

  // Window update terms
  logic [SUM_BITS-1:0]    sum_next;
  logic [CNT_BITS-1:0]    cnt_next;

  // Channel wiring
  assign cfg.ready              = 1'b1;
  assign sample.ready           = in_ready;
  assign result.valid           = out_valid;
  assign result.raw_percent     = out_raw;
  assign result.average_percent = out_avg;

  // Signed offset and span as sign + magnitude
  always_comb begin
    num_neg  = sample.adc_sample < range_low;
    num_mag  = num_neg ? (range_low - sample.adc_sample) : (sample.adc_sample - range_low);
    den_neg  = range_high < range_low;
    den_mag  = den_neg ? (range_low - range_high) : (range_high - range_low);
    raw_zero = (range_low == range_high) || (num_mag == '0) || (num_neg != den_neg);
    raw_full = !raw_zero && (num_mag >= den_mag);
    // offset * 100, then * 256 for the fraction bits
    num_x100 = {1'b0, num_mag, 6'd0} + {2'd0, num_mag, 5'd0} + {5'd0, num_mag, 2'd0};
    raw_dvd  = {num_x100, 8'd0};
  end

  // One restoring division step
  always_comb begin
    trial    = {rem, quo[QUOT_BITS-1]};
    q_bit    = trial >= {1'b0, den};
    rem_step = q_bit ? DEN_BITS'(trial - {1'b0, den}) : DEN_BITS'(trial);
    quo_step = {quo[QUOT_BITS-2:0], q_bit};
  end

  // Running window sum and saturating count
  always_comb begin
    sum_next = win_sum + SUM_BITS'(raw_pct) - SUM_BITS'(history[WINDOW_DEPTH-1]);
    cnt_next = (samples_seen == CNT_BITS'(WINDOW_DEPTH)) ? samples_seen
                                                         : samples_seen + 1'b1;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample.valid) begin
          state_next = (raw_zero || raw_full) ? ST_WINDOW : ST_DIV_RAW;
        end
      end
      ST_DIV_RAW: begin
        if (div_last) begin
          state_next = ST_WINDOW;
        end
      end
      ST_WINDOW:  state_next = ST_DIV_AVG;
      ST_DIV_AVG: begin
        if (div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // State decodes
  always_comb begin
    in_ready = 1'b0;
    div_run  = 1'b0;
    case (state)
      ST_IDLE:    in_ready = 1'b1;
      ST_DIV_RAW: div_run  = 1'b1;
      ST_DIV_AVG: div_run  = 1'b1;
      default:    ;
    endcase
    div_last = div_run && (bit_cnt == BIT_BITS'(QUOT_BITS - 1));
    out_free = !out_valid || result.ready;
  end

  // Control state and window
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      range_low    <= SAMPLE_BITS'(RANGE_LOW_RESET);
      range_high   <= SAMPLE_BITS'(RANGE_HIGH_RESET);
      win_sum      <= '0;
      samples_seen <= '0;
      out_valid    <= 1'b0;
      bit_cnt      <= '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        history[i] <= '0;
      end
    end else begin
      state <= state_next;

      // Register writes, unknown index ignored
      if (cfg.valid) begin
        if (cfg.index == REG_RANGE_LOW) begin
          range_low <= cfg.data;
        end else if (cfg.index == REG_RANGE_HIGH) begin
          range_high <= cfg.data;
        end
      end

      // Bit counter for the serial divider
      if (div_run) begin
        bit_cnt <= div_last ? '0 : bit_cnt + 1'b1;
      end

      // Shift the window and update the sum
      if (state == ST_WINDOW) begin
        for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
          history[i] <= history[i-1];
        end
        history[0]   <= raw_pct;
        win_sum      <= sum_next;
        samples_seen <= cnt_next;
      end

      // Output register
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Divider datapath and result payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (sample.valid) begin
          rem     <= DEN_BITS'(raw_dvd[DVD_BITS-1:QUOT_BITS]);
          quo     <= raw_dvd[QUOT_BITS-1:0];
          den     <= DEN_BITS'(den_mag);
          raw_pct <= raw_full ? PCT_TOP : '0;
        end
      end
      ST_DIV_RAW: begin
        rem <= rem_step;
        quo <= quo_step;
        if (div_last) begin
          raw_pct <= quo_step;
        end
      end
      ST_WINDOW: begin
        // Set up sum / count; the top bits already sit below the count
        rem <= DEN_BITS'(sum_next[SUM_BITS-1:QUOT_BITS]);
        quo <= sum_next[QUOT_BITS-1:0];
        den <= DEN_BITS'(cnt_next);
      end
      ST_DIV_AVG: begin
        rem <= rem_step;
        quo <= quo_step;
      end
      ST_DONE: begin
        if (out_free) begin
          out_raw <= raw_pct;
          out_avg <= quo;
        end
      end
      default: ;
    endcase
  end

  // Checks
  `ASSERT_IMPL(a_div_rem_below_den, clk, rst, div_run, rem < den)
  `ASSERT_ALWAYS(a_count_saturates, clk, rst, samples_seen <= CNT_BITS'(WINDOW_DEPTH))
  `ASSERT_NEXT(a_one_item_in_flight, clk, rst, sample.valid && sample.ready, !sample.ready)
  `ASSERT_IMPL(a_result_in_range, clk, rst, out_valid, (out_raw <= PCT_TOP) && (out_avg <= PCT_TOP))

endmodule
